>>> rtl/nearest_neighbor_tour_builder_macros.svh
// Assertion helpers for the tour builder.
`ifndef NEAREST_NEIGHBOR_TOUR_BUILDER_MACROS_SVH
`define NEAREST_NEIGHBOR_TOUR_BUILDER_MACROS_SVH

`ifndef SYNTHESIS
`define NNTB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("nntb assertion failed");
`define NNTB_NEVER(lbl, bad) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
    else $error("nntb forbidden condition seen");
`else
`define NNTB_ASSERT(lbl, prop)
`define NNTB_NEVER(lbl, bad)
`endif

`endif

>>> rtl/nntb_pkg.sv
package nntb_pkg;

  localparam int CITY_W  = 6;
  localparam int EDGE_W  = 20;
  localparam int TOTAL_W = 26;
  localparam int CFG_W   = 7;

  localparam int MAX_CITIES_DEF = 64;
  localparam int DIST_WIDTH_DEF = 20;

  localparam logic [CFG_W-1:0]   CITY_COUNT_RST = 7'd64;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX      = {TOTAL_W{1'b1}};

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_BUILD = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [CITY_W-1:0] row_city;
    logic [CITY_W-1:0] col_city;
    logic [EDGE_W-1:0] distance;
    logic [CITY_W-1:0] start_city;
  } in_item_t;

  typedef struct packed {
    logic [CITY_W-1:0]  city;
    logic [EDGE_W-1:0]  edge_length;
    logic [TOTAL_W-1:0] total_length;
    logic               last;
    logic               error;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_DRAIN,
    S_PICK,
    S_RET_RD,
    S_RET_WAIT,
    S_EMIT
  } nntb_state_t;

endpackage

>>> rtl/nearest_neighbor_tour_builder.sv
// Greedy nearest-neighbor tour builder.
// Input channel (in_valid/in_stall, in_data): a write item stores one distance
// entry in the matrix memory and returns nothing; writes can transfer
// back to back. A build item names a start city; the block then
// streams the tour on the result channel (out_valid/out_stall, out_data), one
// transfer per city in visiting order, the last one flagged and its total
// including the return edge. A bad start city gives a single transfer with
// error and last set, loaded in the start state once the output register is free.
// Config channel (cfg_valid/cfg_ready, cfg_data) writes city_count while idle.
// Tour steps, with n the city count in use: each step scans n entries of one
// matrix row through the single read port of the distance memory, one entry a
// cycle, then drains the read register, picks the nearest unvisited city and
// emits it; the last step also reads the return edge. in_stall stays high
// from the build transfer until the last result of the tour is loaded.
// A finished result sits in the output register; a stalled receiver holds
// the sequencer at its next result until the register frees up.
// Synchronous reset (rst_n low) clears the sequencer, the visited map and
// the output valid, and sets city_count to 64. The matrix is not cleared.
`include "nearest_neighbor_tour_builder_macros.svh"

module nearest_neighbor_tour_builder
  import nntb_pkg::*;
#(
  parameter int MAX_CITIES = MAX_CITIES_DEF,
  parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IDXW  = $clog2(MAX_CITIES);
  localparam int CNTW  = $clog2(MAX_CITIES + 1);
  localparam int ADDRW = 2 * IDXW;
  localparam int DEPTH = 1 << ADDRW;
  localparam int SUM_W = ((DIST_WIDTH > TOTAL_W) ? DIST_WIDTH : TOTAL_W) + 1;

  nntb_state_t state_r, state_nxt;

  logic [DIST_WIDTH-1:0] mem [DEPTH];
  logic [DIST_WIDTH-1:0] rd_data_r;
  logic [ADDRW-1:0]      rd_addr;
  logic                  mem_we;

  logic [CFG_W-1:0]      city_count_r;
  logic [CNTW-1:0]       n_use;
  logic [CNTW-1:0]       n_r;
  logic [CITY_W-1:0]     start_r;
  logic                  err_r;
  logic [MAX_CITIES-1:0] visited_r;
  logic [CNTW-1:0]       step_r;
  logic [IDXW-1:0]       cur_r;
  logic [IDXW-1:0]       j_r;
  logic                  p_valid_r;
  logic [IDXW-1:0]       p_idx_r;
  logic                  found_r;
  logic [IDXW-1:0]       best_r;
  logic [DIST_WIDTH-1:0] best_d_r;
  logic [DIST_WIDTH-1:0] edge_r;
  logic [TOTAL_W-1:0]    total_r;
  logic                  last_r;

  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic                  in_xfer;
  logic                  out_free;
  logic                  out_load;
  logic                  scan_end;
  logic                  last_step;
  logic [DIST_WIDTH-1:0] addend;
  logic [SUM_W-1:0]      sum;
  logic [TOTAL_W-1:0]    total_sat;

  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_end  = (CNTW'(j_r) == (n_r - CNTW'(1)));
  assign last_step = ((step_r + CNTW'(1)) == n_r);

  always_comb begin
    if (city_count_r == '0) begin
      n_use = CNTW'(1);
    end else if (int'(city_count_r) > MAX_CITIES) begin
      n_use = CNTW'(MAX_CITIES);
    end else begin
      n_use = CNTW'(city_count_r);
    end
  end

  // shared saturating adder
  assign addend    = (state_r == S_RET_WAIT) ? rd_data_r : best_d_r;
  assign sum       = SUM_W'(total_r) + SUM_W'(addend);
  assign total_sat = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_data.operation == OP_BUILD) state_nxt = S_START;
      end
      S_START: begin
        if (err_r) begin
          if (out_free) state_nxt = S_IDLE;
        end else if (n_r == CNTW'(1)) begin
          state_nxt = S_RET_RD;
        end else if (out_free) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) state_nxt = S_DRAIN;
      end
      S_DRAIN:    state_nxt = S_PICK;
      S_PICK:     state_nxt = last_step ? S_RET_RD : S_EMIT;
      S_RET_RD:   state_nxt = S_RET_WAIT;
      S_RET_WAIT: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) state_nxt = last_r ? S_IDLE : S_SCAN;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != S_IDLE);
    cfg_ready = (state_r == S_IDLE);
    out_load  = 1'b0;
    rd_addr   = {cur_r, j_r};
    unique case (state_r)
      S_START:  out_load = out_free && (err_r || n_r != CNTW'(1));
      S_RET_RD: rd_addr  = {cur_r, IDXW'(start_r)};
      S_EMIT:   out_load = out_free;
      default:  out_load = 1'b0;
    endcase
  end

  assign mem_we = in_xfer && in_data.operation == OP_WRITE &&
                  int'(in_data.row_city) < MAX_CITIES &&
                  int'(in_data.col_city) < MAX_CITIES;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{IDXW'(in_data.row_city), IDXW'(in_data.col_city)}] <= DIST_WIDTH'(in_data.distance);
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      city_count_r <= CITY_COUNT_RST;
      visited_r    <= '0;
      step_r       <= '0;
      cur_r        <= '0;
      total_r      <= '0;
      found_r      <= 1'b0;
      p_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_valid_r <= (state_r == S_SCAN) && !visited_r[j_r];
      if (cfg_valid && cfg_ready) city_count_r <= cfg_data;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (p_valid_r && (!found_r || rd_data_r < best_d_r)) found_r <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer && in_data.operation == OP_BUILD) begin
            visited_r <= '0;
            step_r    <= '0;
          end
        end
        S_START: begin
          if (!err_r && (n_r == CNTW'(1) || out_free)) begin
            visited_r[IDXW'(start_r)] <= 1'b1;
            step_r  <= CNTW'(1);
            cur_r   <= IDXW'(start_r);
            total_r <= '0;
            found_r <= 1'b0;
          end
        end
        S_PICK: begin
          visited_r[best_r] <= 1'b1;
          step_r  <= step_r + CNTW'(1);
          cur_r   <= best_r;
          total_r <= total_sat;
        end
        S_RET_WAIT: total_r <= total_sat;
        S_EMIT: begin
          if (out_free) found_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_xfer && in_data.operation == OP_BUILD) begin
      start_r <= in_data.start_city;
      n_r     <= n_use;
      err_r   <= int'(in_data.start_city) >= int'(n_use);
    end
    if (state_r == S_START) begin
      j_r    <= '0;
      edge_r <= '0;
      last_r <= 1'b1;
    end else if (state_r == S_SCAN) begin
      j_r <= j_r + IDXW'(1);
    end else if (state_r == S_PICK) begin
      edge_r <= best_d_r;
      last_r <= last_step;
    end else if (state_r == S_EMIT) begin
      j_r <= '0;
    end
    if (p_valid_r && (!found_r || rd_data_r < best_d_r)) begin
      best_r   <= p_idx_r;
      best_d_r <= rd_data_r;
    end
    p_idx_r <= j_r;
    if (out_load) begin
      if (state_r == S_START) begin
        out_data_r.city         <= start_r;
        out_data_r.edge_length  <= '0;
        out_data_r.total_length <= '0;
        out_data_r.last         <= err_r;
        out_data_r.error        <= err_r;
      end else begin
        out_data_r.city         <= CITY_W'(cur_r);
        out_data_r.edge_length  <= EDGE_W'(edge_r);
        out_data_r.total_length <= total_r;
        out_data_r.last         <= last_r;
        out_data_r.error        <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `NNTB_ASSERT(a_visit_count, $countones(visited_r) == int'(step_r))
  `NNTB_ASSERT(a_pick_fresh, state_r == S_PICK |-> found_r && !visited_r[best_r])
  `NNTB_ASSERT(a_build_busy, in_xfer && in_data.operation == OP_BUILD |=> in_stall)
  `NNTB_NEVER(a_err_last, out_valid_r && out_data_r.error && !out_data_r.last)

endmodule

>>> test/tb_nearest_neighbor_tour_builder.sv
module tb_nearest_neighbor_tour_builder;
  timeunit 1ns;
  timeprecision 1ps;

  import nntb_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYC = 8;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  nearest_neighbor_tour_builder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  logic [EDGE_W-1:0] dist_mem [MAX_CITIES_DEF][MAX_CITIES_DEF];
  bit                written  [MAX_CITIES_DEF][MAX_CITIES_DEF];
  logic [CFG_W-1:0]  city_cnt = CITY_COUNT_RST;
  out_item_t         tour_q [$];
  out_item_t         want_r;

  int fail_cnt = 0;
  int idle_cnt = 0;
  int n_writes = 0;
  int n_tours = 0;
  int n_bad = 0;
  int n_results = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit quiet = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) hold_left = 0;
      else if (hold_left == 0 && $urandom_range(0, 99) < stall_pct)
        hold_left = $urandom_range(1, 12);
      out_stall = (hold_left > 0);
      if (hold_left > 0) hold_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (tour_q.size() == 0) begin
        $error("unexpected result transfer, city %0d", out_data.city);
        fail_cnt++;
      end else begin
        want_r = tour_q.pop_front();
        if (out_data.city !== want_r.city) begin
          $error("city: expected %0d, got %0d", want_r.city, out_data.city);
          fail_cnt++;
        end
        if (out_data.edge_length !== want_r.edge_length) begin
          $error("edge_length: expected %0d, got %0d",
                 want_r.edge_length, out_data.edge_length);
          fail_cnt++;
        end
        if (out_data.total_length !== want_r.total_length) begin
          $error("total_length: expected %0d, got %0d",
                 want_r.total_length, out_data.total_length);
          fail_cnt++;
        end
        if (out_data.last !== want_r.last) begin
          $error("last: expected %0d, got %0d", want_r.last, out_data.last);
          fail_cnt++;
        end
        if (out_data.error !== want_r.error) begin
          $error("error: expected %0d, got %0d", want_r.error, out_data.error);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("tb_nearest_neighbor_tour_builder: done, errors");
      $finish;
    end
  end

  function automatic int eff_count();
    if (city_cnt == 0) return 1;
    if (city_cnt > MAX_CITIES_DEF) return MAX_CITIES_DEF;
    return int'(city_cnt);
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [EDGE_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = a + b;
    return (s > TOTAL_MAX) ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

  function automatic void queue_want(input out_item_t r);
    tour_q = {tour_q, r};
  endfunction

  // greedy tour from start; ties go to the lowest city index
  function automatic void predict_tour(input logic [CITY_W-1:0] start);
    int n, cur, best, step;
    bit seen [MAX_CITIES_DEF];
    bit found;
    logic [EDGE_W-1:0] best_d;
    logic [TOTAL_W-1:0] total;
    out_item_t r;
    n = eff_count();
    n_tours++;
    if (start >= n) begin
      r = '{city: start, edge_length: '0, total_length: '0, last: 1'b1, error: 1'b1};
      queue_want(r);
      n_bad++;
      return;
    end
    total = '0;
    if (n == 1) begin
      total = sat_add(total, dist_mem[start][start]);
      r = '{city: start, edge_length: '0, total_length: total, last: 1'b1, error: 1'b0};
      queue_want(r);
      return;
    end
    r = '{city: start, edge_length: '0, total_length: '0, last: 1'b0, error: 1'b0};
    queue_want(r);
    seen = '{default: 1'b0};
    seen[start] = 1'b1;
    cur = start;
    for (step = 1; step < n; step++) begin
      found = 1'b0;
      best = 0;
      best_d = '0;
      for (int j = 0; j < n; j++) begin
        if (!seen[j] && (!found || dist_mem[cur][j] < best_d)) begin
          found = 1'b1;
          best = j;
          best_d = dist_mem[cur][j];
        end
      end
      seen[best] = 1'b1;
      cur = best;
      total = sat_add(total, best_d);
      if (step == n - 1) total = sat_add(total, dist_mem[best][start]);
      r = '{city: CITY_W'(best), edge_length: best_d, total_length: total,
            last: (step == n - 1), error: 1'b0};
      queue_want(r);
    end
  endfunction

  function automatic logic [EDGE_W-1:0] rand_dist();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return EDGE_W'($urandom_range(0, 3));
    if (k == 4) return '0;
    if (k == 5) return '1;
    return EDGE_W'($urandom_range(0, 20'hFFFFF));
  endfunction

  function automatic in_item_t write_item(input logic [CITY_W-1:0] r, c,
                                          input logic [EDGE_W-1:0] d);
    in_item_t it;
    it.operation  = OP_WRITE;
    it.row_city   = r;
    it.col_city   = c;
    it.distance   = d;
    it.start_city = CITY_W'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic in_item_t build_item(input logic [CITY_W-1:0] s);
    in_item_t it;
    it.operation  = OP_BUILD;
    it.row_city   = CITY_W'($urandom_range(0, 63));
    it.col_city   = CITY_W'($urandom_range(0, 63));
    it.distance   = EDGE_W'($urandom_range(0, 20'hFFFFF));
    it.start_city = s;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 12);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    if (it.operation == OP_WRITE) begin
      dist_mem[it.row_city][it.col_city] = it.distance;
      written[it.row_city][it.col_city] = 1'b1;
      n_writes++;
    end else begin
      predict_tour(it.start_city);
    end
  endtask

  // every entry a build uses gets written first
  task automatic load_missing(input logic [CITY_W-1:0] start);
    int n;
    n = eff_count();
    if (start >= n) return;
    if (n == 1) begin
      if (!written[start][start]) send_item(write_item(start, start, rand_dist()));
      return;
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (i != j && !written[i][j])
          send_item(write_item(CITY_W'(i), CITY_W'(j), rand_dist()));
  endtask

  task automatic run_build(input logic [CITY_W-1:0] start);
    load_missing(start);
    send_item(build_item(start));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tour_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_count(input logic [CFG_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    city_cnt = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_small_tour();
    int unsigned d4 [4][4];
    d4 = '{'{0, 5, 5, 20'hFFFFF}, '{0, 0, 7, 7}, '{3, 1, 0, 0},
           '{20'hFFFFF, 2, 9, 0}};
    gap_pct = 20;
    stall_pct = 20;
    set_count(7'd4);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        if (i != j) send_item(write_item(CITY_W'(i), CITY_W'(j), EDGE_W'(d4[i][j])));
    run_build(6'd0);
    run_build(6'd3);
  endtask

  task automatic test_bad_start();
    send_item(write_item(6'd63, 6'd63, 20'hFFFFF));
    send_item(write_item(6'd0, 6'd0, 20'h0));
    run_build(6'd4);
    run_build(6'd63);
  endtask

  task automatic test_single_city();
    set_count(7'd1);
    send_item(write_item(6'd0, 6'd0, 20'hFFFFF));
    run_build(6'd0);
    run_build(6'd1);
    set_count(7'd0);
    send_item(write_item(6'd0, 6'd0, 20'h5A5A5));
    run_build(6'd0);
    run_build(6'd63);
  endtask

  task automatic test_random_phase(input int items);
    int n, k;
    logic [CITY_W-1:0] s;
    if (!quiet) begin
      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
    end
    set_count(($urandom_range(0, 9) == 0) ? 7'd1 : CFG_W'($urandom_range(2, 12)));
    n = eff_count();
    repeat (items) begin
      k = $urandom_range(0, 99);
      if (k < 20) begin
        s = (k < 17) ? CITY_W'($urandom_range(0, n - 1)) : CITY_W'($urandom_range(0, 63));
        run_build(s);
      end else if (k < 80) begin
        send_item(write_item(CITY_W'($urandom_range(0, n - 1)),
                             CITY_W'($urandom_range(0, n - 1)), rand_dist()));
      end else begin
        send_item(write_item(CITY_W'($urandom_range(0, 63)),
                             CITY_W'($urandom_range(0, 63)), rand_dist()));
      end
    end
  endtask

  task automatic test_random();
    repeat (8) test_random_phase(22);
  endtask

  task automatic test_calm_tail();
    quiet = 1'b1;
    gap_pct = 0;
    stall_pct = 0;
    test_random_phase(30);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_small_tour();
    test_bad_start();
    test_single_city();
    test_random();
    test_calm_tail();

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d matrix writes, %0d tour builds (%0d bad start), %0d result transfers",
             n_writes, n_tours, n_bad, n_results);
    $display("city counts 0, 1, 4 and random 2..12, stalls and gaps on both sides");
    if (fail_cnt == 0)
      $display("tb_nearest_neighbor_tour_builder: done, clean");
    else
      $display("tb_nearest_neighbor_tour_builder: done, errors");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/nntb_pkg.sv
rtl/nearest_neighbor_tour_builder.sv
test/tb_nearest_neighbor_tour_builder.sv
